FILE: rtl/snag_pkg.sv
// ============================================================================
// Stencil neighbor address generator package
// Shared widths, register indexes, mode codes, stage types and the stencil
// offset tables.
// ============================================================================
package snag_pkg;

    localparam int COORD_W = 10;
    localparam int EXT_W   = 11;
    localparam int ADDR_W  = 30;
    localparam int SLOT_W  = 5;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 11;
    localparam int MODE_W  = 3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DIMX = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DIMY = 2'd2;
    localparam logic [CIDX_W-1:0] REG_DIMZ = 2'd3;

    // Stencil mode codes.
    localparam logic [MODE_W-1:0] MODE_1D3  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_1D5  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_2D5  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_2D9  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_3D7  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_3D27 = 3'd6;

    // Dimensionality codes.
    localparam logic [1:0] DIMS_1 = 2'd1;
    localparam logic [1:0] DIMS_2 = 2'd2;
    localparam logic [1:0] DIMS_3 = 2'd3;

    typedef struct packed {
        logic [EXT_W-1:0] nx;
        logic [EXT_W-1:0] ny;
        logic [EXT_W-1:0] nz;
    } t_geom;

    typedef struct packed {
        logic signed [2:0] di;
        logic signed [2:0] dj;
        logic signed [2:0] dk;
    } t_offs;

    // One neighbor request leaving the sequencer.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic [1:0]        dims;
        t_offs             offs;
        logic [EXT_W-1:0]  ci;
        logic [EXT_W-1:0]  cj;
        logic [EXT_W-1:0]  ck;
    } t_slot_req;

    function automatic logic mode_ok(input logic [MODE_W-1:0] mode);
        mode_ok = (mode == MODE_1D3) || (mode == MODE_1D5) || (mode == MODE_2D5) ||
                  (mode == MODE_2D9) || (mode == MODE_3D7) || (mode == MODE_3D27);
    endfunction

    function automatic logic [SLOT_W-1:0] mode_last(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_1D3:  mode_last = 5'd2;
            MODE_1D5:  mode_last = 5'd4;
            MODE_2D5:  mode_last = 5'd4;
            MODE_2D9:  mode_last = 5'd8;
            MODE_3D7:  mode_last = 5'd6;
            MODE_3D27: mode_last = 5'd26;
            default:   mode_last = 5'd0;
        endcase
    endfunction

    function automatic logic [1:0] mode_dims(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_1D3, MODE_1D5:  mode_dims = DIMS_1;
            MODE_2D5, MODE_2D9:  mode_dims = DIMS_2;
            MODE_3D7, MODE_3D27: mode_dims = DIMS_3;
            default:             mode_dims = DIMS_1;
        endcase
    endfunction

    function automatic t_offs mk(input int di, input int dj, input int dk);
        t_offs o;
        o.di = 3'(di);
        o.dj = 3'(dj);
        o.dk = 3'(dk);
        mk = o;
    endfunction

    // Offset of a slot within the selected stencil, in read-list order.
    function automatic t_offs get_offs(input logic [MODE_W-1:0] mode,
                                       input logic [SLOT_W-1:0] slot);
        t_offs o;
        o = mk(0, 0, 0);
        case (mode)
            MODE_1D3: begin
                case (slot)
                    5'd0:    o = mk(-1, 0, 0);
                    5'd2:    o = mk(1, 0, 0);
                    default: o = mk(0, 0, 0);
                endcase
            end
            MODE_1D5: begin
                case (slot)
                    5'd0:    o = mk(-2, 0, 0);
                    5'd1:    o = mk(-1, 0, 0);
                    5'd3:    o = mk(1, 0, 0);
                    5'd4:    o = mk(2, 0, 0);
                    default: o = mk(0, 0, 0);
                endcase
            end
            MODE_2D5, MODE_2D9: begin
                case (slot)
                    5'd0:    o = mk(-1, 0, 0);
                    5'd2:    o = mk(1, 0, 0);
                    5'd3:    o = mk(0, -1, 0);
                    5'd4:    o = mk(0, 1, 0);
                    5'd5:    o = mk(-1, -1, 0);
                    5'd6:    o = mk(1, -1, 0);
                    5'd7:    o = mk(-1, 1, 0);
                    5'd8:    o = mk(1, 1, 0);
                    default: o = mk(0, 0, 0);
                endcase
            end
            MODE_3D7, MODE_3D27: begin
                case (slot)
                    5'd0:    o = mk(-1, 0, 0);
                    5'd2:    o = mk(1, 0, 0);
                    5'd3:    o = mk(0, -1, 0);
                    5'd4:    o = mk(0, 1, 0);
                    5'd5:    o = mk(0, 0, -1);
                    5'd6:    o = mk(0, 0, 1);
                    5'd7:    o = mk(-1, 0, -1);
                    5'd8:    o = mk(1, 0, -1);
                    5'd9:    o = mk(0, -1, -1);
                    5'd10:   o = mk(0, 1, -1);
                    5'd11:   o = mk(-1, -1, 0);
                    5'd12:   o = mk(-1, 1, 0);
                    5'd13:   o = mk(1, -1, 0);
                    5'd14:   o = mk(1, 1, 0);
                    5'd15:   o = mk(-1, 0, 1);
                    5'd16:   o = mk(1, 0, 1);
                    5'd17:   o = mk(0, -1, 1);
                    5'd18:   o = mk(0, 1, 1);
                    5'd19:   o = mk(-1, -1, -1);
                    5'd20:   o = mk(-1, 1, -1);
                    5'd21:   o = mk(1, -1, -1);
                    5'd22:   o = mk(1, 1, -1);
                    5'd23:   o = mk(-1, -1, 1);
                    5'd24:   o = mk(-1, 1, 1);
                    5'd25:   o = mk(1, -1, 1);
                    5'd26:   o = mk(1, 1, 1);
                    default: o = mk(0, 0, 0);
                endcase
            end
            default: o = mk(0, 0, 0);
        endcase
        get_offs = o;
    endfunction

endpackage

FILE: rtl/snag_seq.sv
// ============================================================================
// Stencil neighbor sequencer
// Holds one waiting grid point and walks the active point through its
// stencil slots, one slot per cycle.
// ============================================================================
module snag_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [snag_pkg::MODE_W-1:0]    i_mode,
    input  snag_pkg::t_geom                i_geom,
    input  logic [snag_pkg::COORD_W-1:0]   i_coord_i,
    input  logic [snag_pkg::COORD_W-1:0]   i_coord_j,
    input  logic [snag_pkg::COORD_W-1:0]   i_coord_k,
    output snag_pkg::t_slot_req            o_req
);
    import snag_pkg::*;

    logic               r_hold_v;
    logic [EXT_W-1:0]   r_hold_ci, r_hold_cj, r_hold_ck;
    logic               r_act_v;
    logic [EXT_W-1:0]   r_ci, r_cj, r_ck;
    logic [SLOT_W-1:0]  r_slot;

    logic               accept;
    logic               last;
    logic               adv;
    logic [EXT_W-1:0]   sat_i, sat_j, sat_k;

    // Coordinates beyond the extent are clamped to the last grid index.
    function automatic logic [EXT_W-1:0] sat_coord(input logic [COORD_W-1:0] c,
                                                   input logic [EXT_W-1:0] ext);
        logic [EXT_W-1:0] cx;
        cx = EXT_W'(c);
        sat_coord = (cx >= ext) ? ext - 1'b1 : cx;
    endfunction

    assign accept = i_start & ~r_hold_v;
    assign last   = (r_slot == mode_last(i_mode));
    assign adv    = ~r_act_v | last;
    assign o_busy = r_hold_v;

    assign sat_i = sat_coord(i_coord_i, i_geom.nx);
    assign sat_j = sat_coord(i_coord_j, i_geom.ny);
    assign sat_k = sat_coord(i_coord_k, i_geom.nz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_act_v  <= 1'b0;
            r_slot   <= '0;
        end else begin
            if (adv) begin
                r_act_v <= r_hold_v;
                r_slot  <= '0;
                if (r_hold_v) begin
                    r_hold_v <= 1'b0;
                end
            end else begin
                r_slot <= r_slot + 1'b1;
            end
            // A point under an undefined mode is taken but never queued.
            if (accept && mode_ok(i_mode)) begin
                r_hold_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold_ci <= sat_i;
            r_hold_cj <= sat_j;
            r_hold_ck <= sat_k;
        end
        if (adv && r_hold_v) begin
            r_ci <= r_hold_ci;
            r_cj <= r_hold_cj;
            r_ck <= r_hold_ck;
        end
    end

    always_comb begin
        o_req.valid = r_act_v;
        o_req.slot  = r_slot;
        o_req.last  = last;
        o_req.dims  = mode_dims(i_mode);
        o_req.offs  = get_offs(i_mode, r_slot);
        o_req.ci    = r_ci;
        o_req.cj    = r_cj;
        o_req.ck    = r_ck;
    end

endmodule

FILE: rtl/snag_addr_pipe.sv
// ============================================================================
// Stencil address pipeline
// Three register stages: periodic wrap, inner multiply-add, outer
// multiply-add, with the centre address computed in a parallel lane.
// ============================================================================
module snag_addr_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  snag_pkg::t_geom               i_geom,
    input  snag_pkg::t_slot_req           i_req,
    output logic                          o_strobe,
    output logic [snag_pkg::SLOT_W-1:0]   o_slot,
    output logic [snag_pkg::ADDR_W-1:0]   o_read_address,
    output logic [snag_pkg::ADDR_W-1:0]   o_center_address,
    output logic                          o_last
);
    import snag_pkg::*;

    localparam int K_W = 2 * EXT_W + 1;
    localparam int P_W = K_W + EXT_W + 1;

    // Wrap c+d into [0, ext) for d in -2..2 and c < ext.
    function automatic logic [EXT_W-1:0] wrap(input logic [EXT_W-1:0] c,
                                              input logic signed [2:0] d,
                                              input logic [EXT_W-1:0] ext);
        logic [EXT_W:0] t;
        logic [EXT_W:0] m;
        if (d < 0) begin
            m = (d == -3'sd1) ? (EXT_W+1)'(1) : (EXT_W+1)'(2);
            if ({1'b0, c} >= m) begin
                t = {1'b0, c} - m;
            end else begin
                t = {1'b0, c} + {1'b0, ext} - m;
            end
        end else begin
            t = {1'b0, c} + (EXT_W+1)'(d[1:0]);
            if (t >= {1'b0, ext}) begin
                t = t - {1'b0, ext};
            end
        end
        wrap = t[EXT_W-1:0];
    endfunction

    // Stage 1: wrapped neighbor coordinates.
    logic               r1_v, r1_last;
    logic [SLOT_W-1:0]  r1_slot;
    logic [1:0]         r1_dims;
    logic [EXT_W-1:0]   r1_a, r1_b, r1_c, r1_ca, r1_cb, r1_cc;
    // Stage 2: inner index.
    logic               r2_v, r2_last;
    logic [SLOT_W-1:0]  r2_slot;
    logic [1:0]         r2_dims;
    logic [K_W-1:0]     r2_k, r2_ck;
    logic [EXT_W-1:0]   r2_c, r2_cc;
    // Stage 3: final addresses.
    logic               r3_v, r3_last;
    logic [SLOT_W-1:0]  r3_slot;
    logic [ADDR_W-1:0]  r3_addr, r3_caddr;

    logic [EXT_W-1:0]   n1_a, n1_b, n1_c;
    logic [EXT_W-1:0]   mul2;
    logic [K_W-1:0]     n2_k, n2_ck;
    logic [P_W-1:0]     n3_p, n3_cp;

    assign n1_a = wrap(i_req.ci, i_req.offs.di, i_geom.nx);
    assign n1_b = wrap(i_req.cj, i_req.offs.dj, i_geom.ny);
    assign n1_c = wrap(i_req.ck, i_req.offs.dk, i_geom.nz);

    always_comb begin
        mul2 = (r1_dims == DIMS_2) ? i_geom.nx : i_geom.ny;
        if (r1_dims == DIMS_1) begin
            n2_k  = K_W'(r1_a);
            n2_ck = K_W'(r1_ca);
        end else begin
            n2_k  = K_W'(mul2 * r1_a) + K_W'(r1_b);
            n2_ck = K_W'(mul2 * r1_ca) + K_W'(r1_cb);
        end
        if (r2_dims == DIMS_3) begin
            n3_p  = P_W'(i_geom.nz * r2_k) + P_W'(r2_c);
            n3_cp = P_W'(i_geom.nz * r2_ck) + P_W'(r2_cc);
        end else begin
            n3_p  = P_W'(r2_k);
            n3_cp = P_W'(r2_ck);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_req.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_slot  <= i_req.slot;
        r1_last  <= i_req.last;
        r1_dims  <= i_req.dims;
        r1_a     <= n1_a;
        r1_b     <= n1_b;
        r1_c     <= n1_c;
        r1_ca    <= i_req.ci;
        r1_cb    <= i_req.cj;
        r1_cc    <= i_req.ck;

        r2_slot  <= r1_slot;
        r2_last  <= r1_last;
        r2_dims  <= r1_dims;
        r2_k     <= n2_k;
        r2_ck    <= n2_ck;
        r2_c     <= r1_c;
        r2_cc    <= r1_cc;

        r3_slot  <= r2_slot;
        r3_last  <= r2_last;
        r3_addr  <= n3_p[ADDR_W-1:0];
        r3_caddr <= n3_cp[ADDR_W-1:0];
    end

    assign o_strobe         = r3_v;
    assign o_slot           = r3_slot;
    assign o_read_address   = r3_addr;
    assign o_center_address = r3_caddr;
    assign o_last           = r3_last;

endmodule

FILE: rtl/stencil_neighbor_address_gen.sv
// ============================================================================
// Stencil neighbor address generator
// Turns a grid point into the periodic-wrapped linear read addresses of its
// stencil neighbors, one address per cycle.
// ============================================================================
// A grid point is taken at a clock edge where start is high and busy is low.
// The block then emits one result per cycle on o_strobe, one for each slot of
// the selected stencil: 3, 5, 5, 9, 7 or 27 results per point for modes one
// through six, in the order that the slot sequencer walks them. When the
// block was idle, the first result of a point passes from the waiting
// register through the slot walk and the wrap, inner and outer stages.
// Results cannot be held off: o_strobe marks each result for exactly one
// cycle and the receiver must take it then. While a point is being walked,
// one more point may be transferred and waits; busy rises while that waiting
// place is full. A point transferred under an undefined mode produces no
// results. Configuration may be written only while no results are pending.
module stencil_neighbor_address_gen #(
    parameter int MAX_DIM = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Point command.
    input  logic                           start,
    output logic                           busy,
    input  logic [snag_pkg::COORD_W-1:0]   i_coord_i,
    input  logic [snag_pkg::COORD_W-1:0]   i_coord_j,
    input  logic [snag_pkg::COORD_W-1:0]   i_coord_k,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [snag_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [snag_pkg::CDAT_W-1:0]    i_cfg_data,
    // Results.
    output logic                           o_strobe,
    output logic [snag_pkg::SLOT_W-1:0]    o_neighbor_slot,
    output logic [snag_pkg::ADDR_W-1:0]    o_read_address,
    output logic [snag_pkg::ADDR_W-1:0]    o_center_address,
    output logic                           o_last_of_point
);
    import snag_pkg::*;

    // Largest extent the 11-bit registers can carry under this MAX_DIM.
    localparam int EXT_MAX_I = (MAX_DIM > (2 ** EXT_W) - 1) ? (2 ** EXT_W) - 1 : MAX_DIM;
    localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(EXT_MAX_I);
    localparam logic [EXT_W-1:0] EXT_MIN = EXT_W'(3);
    localparam logic [EXT_W-1:0] EXT_RST = EXT_W'(1024);

    logic [MODE_W-1:0] r_mode;
    t_geom             r_geom;
    t_slot_req         req;

    // Extents are stored already clamped to the supported range, which is
    // the only form in which the address logic ever uses them.
    function automatic logic [EXT_W-1:0] sat_ext(input logic [EXT_W-1:0] v);
        if (v < EXT_MIN) begin
            sat_ext = EXT_MIN;
        end else if (v > EXT_MAX) begin
            sat_ext = EXT_MAX;
        end else begin
            sat_ext = v;
        end
    endfunction

    // The user must issue writes only while idle; the block does not enforce it, and the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_1D3;
            r_geom.nx <= sat_ext(EXT_RST);
            r_geom.ny <= sat_ext(EXT_RST);
            r_geom.nz <= sat_ext(EXT_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MODE: r_mode    <= i_cfg_data[MODE_W-1:0];
                REG_DIMX: r_geom.nx <= sat_ext(i_cfg_data);
                REG_DIMY: r_geom.ny <= sat_ext(i_cfg_data);
                REG_DIMZ: r_geom.nz <= sat_ext(i_cfg_data);
                default:  r_mode    <= r_mode;
            endcase
        end
    end

    // Stage 0: waiting point and slot walk.
    snag_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_mode    (r_mode),
        .i_geom    (r_geom),
        .i_coord_i (i_coord_i),
        .i_coord_j (i_coord_j),
        .i_coord_k (i_coord_k),
        .o_req     (req)
    );

    // Stages 1 to 3: wrap, inner multiply-add, outer multiply-add.
    snag_addr_pipe u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_geom           (r_geom),
        .i_req            (req),
        .o_strobe         (o_strobe),
        .o_slot           (o_neighbor_slot),
        .o_read_address   (o_read_address),
        .o_center_address (o_center_address),
        .o_last           (o_last_of_point)
    );

endmodule
